/* hdl/c8ic_pkg.sv */
// shared types, constants and decode helpers for the chip-8 instruction core
// no dependencies; imported by c8ic_ctrl, c8ic_dp and chip8_instruction_core_top
package c8ic_pkg;

    // sizes
    localparam int MEM_BYTES     = 4096;
    localparam int MEM_AW        = 12;
    localparam int SCREEN_COLS   = 64;
    localparam int SCREEN_ROWS   = 32;
    localparam int ROW_AW        = 5;
    localparam int REG_COUNT     = 16;
    localparam int REG_AW        = 4;
    localparam int STACK_ENTRIES = 16;
    localparam int STACK_AW      = $clog2(STACK_ENTRIES);
    localparam int GLYPH_BYTES   = 5;
    localparam int IN_DATA_W     = 48;
    localparam int OUT_DATA_W    = 96;
    localparam int APB_AW        = 3;

    // reset values of the configuration registers
    localparam logic [MEM_AW-1:0] PC_RESET   = 12'd512;
    localparam logic [MEM_AW-1:0] FONT_RESET = 12'd80;

    // configuration register byte addresses
    localparam logic [APB_AW-1:0] CFG_PROGRAM_START = 3'd0;
    localparam logic [APB_AW-1:0] CFG_FONT_BASE     = 3'd4;

    localparam logic [REG_AW-1:0] FLAG_REG = 4'hF;

    // item kinds
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_EXEC  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_ROW   = 2'd3
    } t_mode;

    // opcode groups (top nibble)
    localparam logic [3:0] OP_SYS         = 4'h0;
    localparam logic [3:0] OP_JUMP        = 4'h1;
    localparam logic [3:0] OP_CALL        = 4'h2;
    localparam logic [3:0] OP_SKIP_EQ_NN  = 4'h3;
    localparam logic [3:0] OP_SKIP_NE_NN  = 4'h4;
    localparam logic [3:0] OP_SKIP_EQ_REG = 4'h5;
    localparam logic [3:0] OP_LOAD_NN     = 4'h6;
    localparam logic [3:0] OP_ADD_NN      = 4'h7;
    localparam logic [3:0] OP_ALU         = 4'h8;
    localparam logic [3:0] OP_SKIP_NE_REG = 4'h9;
    localparam logic [3:0] OP_SET_INDEX   = 4'hA;
    localparam logic [3:0] OP_JUMP_V0     = 4'hB;
    localparam logic [3:0] OP_RANDOM      = 4'hC;
    localparam logic [3:0] OP_DRAW        = 4'hD;
    localparam logic [3:0] OP_KEY         = 4'hE;
    localparam logic [3:0] OP_MISC        = 4'hF;

    // register-register alu functions (low nibble)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // misc functions (low byte)
    localparam logic [7:0] MISC_GET_DELAY = 8'h07;
    localparam logic [7:0] MISC_WAIT_KEY  = 8'h0A;
    localparam logic [7:0] MISC_SET_DELAY = 8'h15;
    localparam logic [7:0] MISC_SET_SOUND = 8'h18;
    localparam logic [7:0] MISC_ADD_INDEX = 8'h1E;
    localparam logic [7:0] MISC_GLYPH     = 8'h29;
    localparam logic [7:0] MISC_BCD       = 8'h33;
    localparam logic [7:0] MISC_STORE     = 8'h55;
    localparam logic [7:0] MISC_LOAD      = 8'h65;

    // whole-word codes
    localparam logic [15:0] W_CLEAR_SCREEN = 16'h00E0;
    localparam logic [15:0] W_RETURN       = 16'h00EE;
    localparam logic [15:0] W_KEY_MASK     = 16'hF0FF;
    localparam logic [15:0] W_KEY_DOWN     = 16'hE09E;
    localparam logic [15:0] W_KEY_UP       = 16'hE0A1;

    // controller states
    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_MWR, ST_TICK, ST_ROW_RD, ST_ROW_CAP,
        ST_FETCH_HI, ST_FETCH_LO, ST_DECODE, ST_RD_X, ST_RD_Y, ST_RD_0,
        ST_EXEC, ST_DRAW_RD, ST_DRAW_WR, ST_BCD_TENS, ST_BCD_ONES,
        ST_STORE_RD, ST_STORE_WR, ST_LOAD_RD, ST_LOAD_WR, ST_FLAG, ST_DONE
    } t_state;

    // datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NONE, UOP_CLEAR, UOP_ACCEPT, UOP_MEM_WRITE, UOP_TICK,
        UOP_ROW_READ, UOP_ROW_CAPTURE, UOP_FETCH_HI, UOP_FETCH_LO,
        UOP_DECODE, UOP_READ_X, UOP_READ_Y, UOP_READ_V0, UOP_EXECUTE,
        UOP_DRAW_READ, UOP_DRAW_WRITE, UOP_BCD_TENS, UOP_BCD_ONES,
        UOP_STORE_READ, UOP_STORE_WRITE, UOP_LOAD_READ, UOP_LOAD_WRITE,
        UOP_FLAG, UOP_PUBLISH
    } t_uop;

    // what follows the execute step
    typedef enum logic [2:0] {
        EC_SIMPLE, EC_FLAG, EC_DRAW, EC_BCD, EC_STORE, EC_LOAD
    } t_exec_class;

    typedef struct packed {
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic        clr_last;
        logic        loop_last;
        logic        draw_empty;
        logic        out_free;
        t_exec_class cls;
    } t_status;

    // classify an instruction word by the sequence it needs
    function automatic t_exec_class f_exec_class(input logic [15:0] ir);
        t_exec_class cls;
        cls = EC_SIMPLE;
        case (ir[15:12])
            OP_ALU: begin
                case (ir[3:0]) inside
                    ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: cls = EC_FLAG;
                    default: cls = EC_SIMPLE;
                endcase
            end
            OP_DRAW: cls = EC_DRAW;
            OP_MISC: begin
                case (ir[7:0])
                    MISC_ADD_INDEX: cls = EC_FLAG;
                    MISC_BCD:       cls = EC_BCD;
                    MISC_STORE:     cls = EC_STORE;
                    MISC_LOAD:      cls = EC_LOAD;
                    default:        cls = EC_SIMPLE;
                endcase
            end
            default: cls = EC_SIMPLE;
        endcase
        return cls;
    endfunction

endpackage

/* hdl/c8ic_ctrl.sv */
// sequencing state machine of the chip-8 instruction core
// depends on c8ic_pkg; drives micro-operations into c8ic_dp
module c8ic_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic [1:0]       i_mode,
    input  c8ic_pkg::t_status i_status,
    output c8ic_pkg::t_cmd    o_cmd,
    output logic             o_s_tready
);
    import c8ic_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:    if (i_status.clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (t_mode'(i_mode))
                        MODE_WRITE: n_state = ST_MWR;
                        MODE_EXEC:  n_state = ST_FETCH_HI;
                        MODE_TICK:  n_state = ST_TICK;
                        MODE_ROW:   n_state = ST_ROW_RD;
                    endcase
                end
            end
            ST_MWR:      n_state = ST_DONE;
            ST_TICK:     n_state = ST_DONE;
            ST_ROW_RD:   n_state = ST_ROW_CAP;
            ST_ROW_CAP:  n_state = ST_DONE;
            ST_FETCH_HI: n_state = ST_FETCH_LO;
            ST_FETCH_LO: n_state = ST_DECODE;
            ST_DECODE:   n_state = ST_RD_X;
            ST_RD_X:     n_state = ST_RD_Y;
            ST_RD_Y:     n_state = ST_RD_0;
            ST_RD_0:     n_state = ST_EXEC;
            ST_EXEC: begin
                unique case (i_status.cls)
                    EC_SIMPLE: n_state = ST_DONE;
                    EC_FLAG:   n_state = ST_FLAG;
                    EC_DRAW:   n_state = i_status.draw_empty ? ST_FLAG : ST_DRAW_RD;
                    EC_BCD:    n_state = ST_BCD_TENS;
                    EC_STORE:  n_state = ST_STORE_RD;
                    EC_LOAD:   n_state = ST_LOAD_RD;
                    default:   n_state = ST_DONE;
                endcase
            end
            ST_DRAW_RD:  n_state = ST_DRAW_WR;
            ST_DRAW_WR:  n_state = i_status.loop_last ? ST_FLAG : ST_DRAW_RD;
            ST_BCD_TENS: n_state = ST_BCD_ONES;
            ST_BCD_ONES: n_state = ST_DONE;
            ST_STORE_RD: n_state = ST_STORE_WR;
            ST_STORE_WR: n_state = i_status.loop_last ? ST_DONE : ST_STORE_RD;
            ST_LOAD_RD:  n_state = ST_LOAD_WR;
            ST_LOAD_WR:  n_state = i_status.loop_last ? ST_DONE : ST_LOAD_RD;
            ST_FLAG:     n_state = ST_DONE;
            ST_DONE:     if (i_status.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // micro-operation per state
    always_comb begin
        o_cmd.uop  = UOP_NONE;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR:    o_cmd.uop = UOP_CLEAR;
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.uop  = i_s_tvalid ? UOP_ACCEPT : UOP_NONE;
            end
            ST_MWR:      o_cmd.uop = UOP_MEM_WRITE;
            ST_TICK:     o_cmd.uop = UOP_TICK;
            ST_ROW_RD:   o_cmd.uop = UOP_ROW_READ;
            ST_ROW_CAP:  o_cmd.uop = UOP_ROW_CAPTURE;
            ST_FETCH_HI: o_cmd.uop = UOP_FETCH_HI;
            ST_FETCH_LO: o_cmd.uop = UOP_FETCH_LO;
            ST_DECODE:   o_cmd.uop = UOP_DECODE;
            ST_RD_X:     o_cmd.uop = UOP_READ_X;
            ST_RD_Y:     o_cmd.uop = UOP_READ_Y;
            ST_RD_0:     o_cmd.uop = UOP_READ_V0;
            ST_EXEC:     o_cmd.uop = UOP_EXECUTE;
            ST_DRAW_RD:  o_cmd.uop = UOP_DRAW_READ;
            ST_DRAW_WR:  o_cmd.uop = UOP_DRAW_WRITE;
            ST_BCD_TENS: o_cmd.uop = UOP_BCD_TENS;
            ST_BCD_ONES: o_cmd.uop = UOP_BCD_ONES;
            ST_STORE_RD: o_cmd.uop = UOP_STORE_READ;
            ST_STORE_WR: o_cmd.uop = UOP_STORE_WRITE;
            ST_LOAD_RD:  o_cmd.uop = UOP_LOAD_READ;
            ST_LOAD_WR:  o_cmd.uop = UOP_LOAD_WRITE;
            ST_FLAG:     o_cmd.uop = UOP_FLAG;
            ST_DONE:     o_cmd.uop = i_status.out_free ? UOP_PUBLISH : UOP_NONE;
            default:     o_cmd.uop = UOP_NONE;
        endcase
    end

endmodule

/* hdl/c8ic_dp.sv */
// datapath of the chip-8 instruction core: memory, frame buffer, register file,
// stack, timers, config registers and output register; depends on c8ic_pkg
module c8ic_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  c8ic_pkg::t_cmd                    i_cmd,
    output c8ic_pkg::t_status                 o_status,
    // mode[1:0]
    input  logic [1:0]                        i_s_tuser,
    // address[11:0], data[19:12], key_mask[35:20], random_byte[43:36]
    input  logic [c8ic_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    // program_counter[11:0], index_value[23:12], bad_opcode[24],
    // screen_changed[25], key_waiting[26], sound_on[27], row_pixels[91:28]
    output logic [c8ic_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c8ic_pkg::APB_AW-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata
);
    import c8ic_pkg::*;

    // latched item
    logic [MEM_AW-1:0]     r_addr;
    logic [7:0]            r_data;
    logic [15:0]           r_keys;
    logic [7:0]            r_rnd;

    // architectural state
    logic [MEM_AW-1:0]     r_pc;
    logic [MEM_AW-1:0]     r_idx;
    logic [STACK_AW-1:0]   r_sp;
    logic [MEM_AW-1:0]     r_stack [STACK_ENTRIES];
    logic [7:0]            r_delay;
    logic [7:0]            r_sound;
    logic [MEM_AW-1:0]     r_prog_start;
    logic [MEM_AW-1:0]     r_font_base;

    // instruction work registers
    logic [15:0]           r_ir;
    logic [7:0]            r_vx;
    logic [7:0]            r_vy;
    logic [REG_AW-1:0]     r_cnt;
    logic [5:0]            r_x0;
    logic [ROW_AW-1:0]     r_y0;
    logic [ROW_AW-1:0]     r_frow;
    logic                  r_flag;
    logic                  r_bad;
    logic                  r_scr;
    logic                  r_wait;
    logic [SCREEN_COLS-1:0] r_row;
    logic [MEM_AW-1:0]     r_clr;

    // memories
    logic [7:0]            r_mem [MEM_BYTES];
    logic [7:0]            r_mem_rd;
    logic [7:0]            r_rf [REG_COUNT];
    logic [REG_COUNT-1:0]  r_rf_vld;
    logic [7:0]            r_rf_rd;
    logic                  r_rf_rd_vld;
    logic [SCREEN_COLS-1:0] r_frame [SCREEN_ROWS];
    logic [SCREEN_ROWS-1:0] r_row_vld;
    logic [SCREEN_COLS-1:0] r_frame_rd;
    logic                  r_frame_rd_vld;

    // output register
    logic                  r_ovld;
    logic [OUT_DATA_W-1:0] r_tdata;

    // instruction fields
    logic [3:0]            op;
    logic [REG_AW-1:0]     fx;
    logic [REG_AW-1:0]     fy;
    logic [3:0]            fn;
    logic [7:0]            nn;
    logic [MEM_AW-1:0]     nnn;

    // port signals
    logic                  mem_we;
    logic [MEM_AW-1:0]     mem_wa;
    logic [7:0]            mem_wd;
    logic [MEM_AW-1:0]     mem_ra;
    logic                  rf_we;
    logic [REG_AW-1:0]     rf_wa;
    logic [7:0]            rf_wd;
    logic [REG_AW-1:0]     rf_ra;
    logic [7:0]            rf_val;
    logic [ROW_AW-1:0]     fr_ra;
    logic [SCREEN_COLS-1:0] frame_val;
    logic [SCREEN_COLS-1:0] sprite_mask;
    logic [MEM_AW-1:0]     idx_cnt;
    logic                  cfg_we;
    logic                  out_free;

    // bcd digits
    logic [1:0]            bcd_h;
    logic [7:0]            bcd_rem;
    logic [15:0]           tens_prod;
    logic [3:0]            bcd_t;
    logic [7:0]            bcd_o;

    // execute results
    logic [MEM_AW-1:0]     ex_pc;
    logic [MEM_AW-1:0]     ex_idx;
    logic                  ex_vx_we;
    logic [7:0]            ex_vx;
    logic                  ex_flag;
    logic                  ex_bad;
    logic                  ex_scr;
    logic                  ex_wait;
    logic                  ex_clear;
    logic                  ex_call;
    logic                  ex_ret;
    logic                  ex_delay_we;
    logic                  ex_sound_we;
    logic [8:0]            add_sum;
    logic [12:0]           idx_sum;
    logic [STACK_AW-1:0]   sp_inc;
    logic [STACK_AW-1:0]   sp_dec;

    // lowest held key
    function automatic logic [3:0] f_low_key(input logic [15:0] keys);
        logic [3:0] k;
        k = '0;
        for (int i = 15; i >= 0; i--) begin
            if (keys[i]) k = 4'(i);
        end
        return k;
    endfunction

    assign op  = r_ir[15:12];
    assign fx  = r_ir[11:8];
    assign fy  = r_ir[7:4];
    assign fn  = r_ir[3:0];
    assign nn  = r_ir[7:0];
    assign nnn = r_ir[11:0];

    assign rf_val      = r_rf_rd_vld ? r_rf_rd : 8'd0;
    assign frame_val   = r_frame_rd_vld ? r_frame_rd : '0;
    assign sprite_mask = {r_mem_rd, 56'd0} >> r_x0;
    assign idx_cnt     = r_idx + {8'd0, r_cnt};
    assign cfg_we      = psel & penable & pwrite;
    assign out_free    = !r_ovld || i_m_tready;

    assign sp_inc = (r_sp == STACK_AW'(STACK_ENTRIES - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec = (r_sp == '0) ? STACK_AW'(STACK_ENTRIES - 1) : r_sp - 1'b1;

    // status to the controller
    always_comb begin
        o_status.clr_last   = &r_clr;
        o_status.draw_empty = (fn == 4'd0);
        o_status.out_free   = out_free;
        o_status.cls        = f_exec_class(r_ir);
        if (op == OP_DRAW) begin
            o_status.loop_last = ({1'b0, r_cnt} + 5'd1 == {1'b0, fn}) ||
                                 (r_frow == ROW_AW'(SCREEN_ROWS - 1));
        end else begin
            o_status.loop_last = (r_cnt == fx);
        end
    end

    // bcd digits of vx
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h   = 2'd2;
            bcd_rem = r_vx - 8'd200;
        end else if (r_vx >= 8'd100) begin
            bcd_h   = 2'd1;
            bcd_rem = r_vx - 8'd100;
        end else begin
            bcd_h   = 2'd0;
            bcd_rem = r_vx;
        end
        tens_prod = {8'd0, bcd_rem} * 16'd205;
        bcd_t     = tens_prod[14:11];
        bcd_o     = bcd_rem - {1'b0, bcd_t, 3'd0} - {3'd0, bcd_t, 1'b0};
    end

    // instruction execute
    always_comb begin
        ex_pc       = r_pc;
        ex_idx      = r_idx;
        ex_vx_we    = 1'b0;
        ex_vx       = r_vx;
        ex_flag     = 1'b0;
        ex_bad      = 1'b0;
        ex_scr      = 1'b0;
        ex_wait     = 1'b0;
        ex_clear    = 1'b0;
        ex_call     = 1'b0;
        ex_ret      = 1'b0;
        ex_delay_we = 1'b0;
        ex_sound_we = 1'b0;
        add_sum     = {1'b0, r_vx} + {1'b0, r_vy};
        idx_sum     = {1'b0, r_idx} + {5'd0, r_vx};
        case (op)
            OP_SYS: begin
                if (r_ir == W_CLEAR_SCREEN) begin
                    ex_clear = 1'b1;
                    ex_scr   = 1'b1;
                end else if (r_ir == W_RETURN) begin
                    ex_ret = 1'b1;
                    ex_pc  = r_stack[sp_dec];
                end
            end
            OP_JUMP: ex_pc = nnn;
            OP_CALL: begin
                ex_call = 1'b1;
                ex_pc   = nnn;
            end
            OP_SKIP_EQ_NN: if (r_vx == nn) ex_pc = r_pc + 12'd2;
            OP_SKIP_NE_NN: if (r_vx != nn) ex_pc = r_pc + 12'd2;
            OP_SKIP_EQ_REG: begin
                if (fn != 4'd0) ex_bad = 1'b1;
                else if (r_vx == r_vy) ex_pc = r_pc + 12'd2;
            end
            OP_LOAD_NN: begin
                ex_vx_we = 1'b1;
                ex_vx    = nn;
            end
            OP_ADD_NN: begin
                ex_vx_we = 1'b1;
                ex_vx    = r_vx + nn;
            end
            OP_ALU: begin
                ex_vx_we = 1'b1;
                case (fn)
                    ALU_MOV: ex_vx = r_vy;
                    ALU_OR:  ex_vx = r_vx | r_vy;
                    ALU_AND: ex_vx = r_vx & r_vy;
                    ALU_XOR: ex_vx = r_vx ^ r_vy;
                    ALU_ADD: begin
                        ex_vx   = add_sum[7:0];
                        ex_flag = add_sum[8];
                    end
                    ALU_SUB: begin
                        ex_vx   = r_vx - r_vy;
                        ex_flag = (r_vx >= r_vy);
                    end
                    ALU_SHR: begin
                        ex_vx   = {1'b0, r_vx[7:1]};
                        ex_flag = r_vx[0];
                    end
                    ALU_SUBN: begin
                        ex_vx   = r_vy - r_vx;
                        ex_flag = (r_vy >= r_vx);
                    end
                    ALU_SHL: begin
                        ex_vx   = {r_vx[6:0], 1'b0};
                        ex_flag = r_vx[7];
                    end
                    default: begin
                        ex_vx_we = 1'b0;
                        ex_bad   = 1'b1;
                    end
                endcase
            end
            OP_SKIP_NE_REG: begin
                if (fn != 4'd0) ex_bad = 1'b1;
                else if (r_vx != r_vy) ex_pc = r_pc + 12'd2;
            end
            OP_SET_INDEX: ex_idx = nnn;
            OP_JUMP_V0:   ex_pc  = nnn + {4'd0, rf_val};
            OP_RANDOM: begin
                ex_vx_we = 1'b1;
                ex_vx    = r_rnd & nn;
            end
            OP_DRAW: ex_scr = 1'b1;
            OP_KEY: begin
                if ((r_ir & W_KEY_MASK) == W_KEY_DOWN) begin
                    if (r_keys[r_vx[3:0]]) ex_pc = r_pc + 12'd2;
                end else if ((r_ir & W_KEY_MASK) == W_KEY_UP) begin
                    if (!r_keys[r_vx[3:0]]) ex_pc = r_pc + 12'd2;
                end else begin
                    ex_bad = 1'b1;
                end
            end
            OP_MISC: begin
                case (nn)
                    MISC_GET_DELAY: begin
                        ex_vx_we = 1'b1;
                        ex_vx    = r_delay;
                    end
                    MISC_WAIT_KEY: begin
                        if (r_keys == 16'd0) begin
                            ex_pc   = r_pc - 12'd2;
                            ex_wait = 1'b1;
                        end else begin
                            ex_vx_we = 1'b1;
                            ex_vx    = {4'd0, f_low_key(r_keys)};
                        end
                    end
                    MISC_SET_DELAY: ex_delay_we = 1'b1;
                    MISC_SET_SOUND: ex_sound_we = 1'b1;
                    MISC_ADD_INDEX: begin
                        ex_idx  = idx_sum[11:0];
                        ex_flag = idx_sum[12];
                    end
                    MISC_GLYPH: begin
                        ex_idx = r_font_base + {6'd0, r_vx[3:0], 2'd0} +
                                 {8'd0, r_vx[3:0]};
                    end
                    MISC_BCD, MISC_STORE, MISC_LOAD: ex_bad = 1'b0;
                    default: ex_bad = 1'b1;
                endcase
            end
            default: ex_bad = 1'b0;
        endcase
    end

    // main memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_idx;
        mem_wd = 8'd0;
        mem_ra = r_pc;
        case (i_cmd.uop)
            UOP_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
            end
            UOP_MEM_WRITE: begin
                mem_we = 1'b1;
                mem_wa = r_addr;
                mem_wd = r_data;
            end
            UOP_EXECUTE: begin
                mem_we = (f_exec_class(r_ir) == EC_BCD);
                mem_wd = {6'd0, bcd_h};
            end
            UOP_BCD_TENS: begin
                mem_we = 1'b1;
                mem_wa = r_idx + 12'd1;
                mem_wd = {4'd0, bcd_t};
            end
            UOP_BCD_ONES: begin
                mem_we = 1'b1;
                mem_wa = r_idx + 12'd2;
                mem_wd = bcd_o;
            end
            UOP_STORE_WRITE: begin
                mem_we = 1'b1;
                mem_wa = idx_cnt;
                mem_wd = rf_val;
            end
            UOP_FETCH_LO:   mem_ra = r_pc + 12'd1;
            UOP_DRAW_READ:  mem_ra = idx_cnt;
            UOP_LOAD_READ:  mem_ra = idx_cnt;
            default:        mem_ra = r_pc;
        endcase
    end

    // register file port selection
    always_comb begin
        rf_we = 1'b0;
        rf_wa = fx;
        rf_wd = ex_vx;
        rf_ra = fx;
        case (i_cmd.uop)
            UOP_READ_Y:     rf_ra = fy;
            UOP_READ_V0:    rf_ra = '0;
            UOP_STORE_READ: rf_ra = r_cnt;
            UOP_EXECUTE:    rf_we = ex_vx_we;
            UOP_FLAG: begin
                rf_we = 1'b1;
                rf_wa = FLAG_REG;
                rf_wd = {7'd0, r_flag};
            end
            UOP_LOAD_WRITE: begin
                rf_we = 1'b1;
                rf_wa = r_cnt;
                rf_wd = r_mem_rd;
            end
            default: rf_we = 1'b0;
        endcase
    end

    // frame row read address
    assign fr_ra = (i_cmd.uop == UOP_DRAW_READ) ? r_y0 + {1'b0, r_cnt} : r_addr[ROW_AW-1:0];

    // main memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_rd <= r_mem[mem_ra];
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        r_rf_rd     <= r_rf[rf_ra];
        r_rf_rd_vld <= r_rf_vld[rf_ra];
    end

    // frame buffer rows
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == UOP_DRAW_WRITE) begin
            r_frame[r_frow] <= frame_val ^ sprite_mask;
        end
        r_frame_rd     <= r_frame[fr_ra];
        r_frame_rd_vld <= r_row_vld[fr_ra];
    end

    // return stack entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == UOP_EXECUTE && ex_call) begin
            r_stack[r_sp] <= r_pc;
        end
    end

    // valid bits of register file and frame rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_row_vld <= '0;
        end else begin
            if (rf_we) r_rf_vld[rf_wa] <= 1'b1;
            if (i_cmd.uop == UOP_EXECUTE && ex_clear) begin
                r_row_vld <= '0;
            end else if (i_cmd.uop == UOP_DRAW_WRITE) begin
                r_row_vld[r_frow] <= 1'b1;
            end
        end
    end

    // control state: pc, index, stack pointer, timers, config, clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PC_RESET;
            r_idx        <= '0;
            r_sp         <= '0;
            r_delay      <= 8'd0;
            r_sound      <= 8'd0;
            r_prog_start <= PC_RESET;
            r_font_base  <= FONT_RESET;
            r_clr        <= '0;
            r_ovld       <= 1'b0;
        end else begin
            if (i_cmd.uop == UOP_CLEAR) r_clr <= r_clr + 12'd1;
            if (i_cmd.uop == UOP_DECODE) r_pc <= r_pc + 12'd2;
            if (i_cmd.uop == UOP_EXECUTE) begin
                r_pc  <= ex_pc;
                r_idx <= ex_idx;
                if (ex_call) r_sp <= sp_inc;
                if (ex_ret) r_sp <= sp_dec;
                if (ex_delay_we) r_delay <= r_vx;
                if (ex_sound_we) r_sound <= r_vx;
            end
            if (i_cmd.uop == UOP_TICK) begin
                if (r_delay != 8'd0) r_delay <= r_delay - 8'd1;
                if (r_sound != 8'd0) r_sound <= r_sound - 8'd1;
            end
            if (cfg_we && paddr == CFG_PROGRAM_START) begin
                r_prog_start <= pwdata[MEM_AW-1:0];
                r_pc         <= pwdata[MEM_AW-1:0];
            end
            if (cfg_we && paddr == CFG_FONT_BASE) begin
                r_font_base <= pwdata[MEM_AW-1:0];
            end
            if (i_cmd.uop == UOP_PUBLISH) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // work registers of the current item
    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            UOP_ACCEPT: begin
                r_addr <= i_s_tdata[11:0];
                r_data <= i_s_tdata[19:12];
                r_keys <= i_s_tdata[35:20];
                r_rnd  <= i_s_tdata[43:36];
                r_bad  <= 1'b0;
                r_scr  <= 1'b0;
                r_wait <= 1'b0;
                r_row  <= '0;
            end
            UOP_ROW_CAPTURE: r_row <= frame_val;
            UOP_FETCH_LO:    r_ir[15:8] <= r_mem_rd;
            UOP_DECODE:      r_ir[7:0] <= r_mem_rd;
            UOP_READ_Y:      r_vx <= rf_val;
            UOP_READ_V0:     r_vy <= rf_val;
            UOP_EXECUTE: begin
                r_flag <= ex_flag;
                r_bad  <= ex_bad;
                r_scr  <= ex_scr;
                r_wait <= ex_wait;
                r_cnt  <= '0;
                r_x0   <= r_vx[5:0];
                r_y0   <= r_vy[ROW_AW-1:0];
            end
            UOP_DRAW_READ: r_frow <= fr_ra;
            UOP_DRAW_WRITE: begin
                r_flag <= r_flag | (|(frame_val & sprite_mask));
                r_cnt  <= r_cnt + 4'd1;
            end
            UOP_STORE_WRITE: r_cnt <= r_cnt + 4'd1;
            UOP_LOAD_WRITE:  r_cnt <= r_cnt + 4'd1;
            default: r_cnt <= r_cnt;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == UOP_PUBLISH) begin
            r_tdata <= {4'd0, r_row, (r_sound != 8'd0), r_wait, r_scr, r_bad, r_idx, r_pc};
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_tdata;

    // config read back
    always_comb begin
        prdata = 32'd0;
        if (paddr == CFG_PROGRAM_START) prdata = {20'd0, r_prog_start};
        else if (paddr == CFG_FONT_BASE) prdata = {20'd0, r_font_base};
    end

endmodule

/* hdl/chip8_instruction_core_top.sv */
// Chip-8 instruction core. After reset the core sweeps its 4096-byte memory to
// zero, one byte a cycle, and takes no item until the sweep is done (config
// writes are taken). Every item then runs through one main memory and one
// register file, each with one read and one write port. A sprite draw reads
// and writes once per row drawn, a bulk store or load once per register, and a
// VF-setting instruction adds a VF write. The result register lets the next
// item be accepted while the previous result waits. Depends on c8ic_pkg,
// c8ic_ctrl and c8ic_dp.
module chip8_instruction_core_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // address[11:0], data[19:12], key_mask[35:20], random_byte[43:36]
    input  logic [c8ic_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // mode[1:0]
    input  logic [1:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // program_counter[11:0], index_value[23:12], bad_opcode[24],
    // screen_changed[25], key_waiting[26], sound_on[27], row_pixels[91:28]
    output logic [c8ic_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c8ic_pkg::APB_AW-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import c8ic_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;

    // sequencer
    c8ic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_mode     (i_s_tuser),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready)
    );

    // storage and execution
    c8ic_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata)
    );

endmodule
